[src/moving_average_filter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the moving average filter
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/maf_pkg.sv]
// ----------------------------------------------------------------------------
// Moving average filter package
// Codes, fixed widths, state encoding and divider status shared by the block.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam int WINDOW_RESET = 8;

  // word function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd2;

  // register index (byte address bit 2)
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_START  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } maf_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } maf_div_stat_t;

endpackage

[src/maf_in_if.sv]
// ----------------------------------------------------------------------------
// Moving average filter input channel
// Valid/ready channel carrying a function code and a sample.
// ----------------------------------------------------------------------------
interface maf_in_if
  import maf_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) ();

  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, func, sample_in, input ready);
  modport sink   (input valid, func, sample_in, output ready);

endinterface

[src/maf_out_if.sv]
// ----------------------------------------------------------------------------
// Moving average filter output channel
// Valid/ready channel carrying the average, ready flag and sample count.
// ----------------------------------------------------------------------------
interface maf_out_if
  import maf_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average_out;
  logic                          ready_flag;
  logic [COUNT_W-1:0]            samples_seen;

  modport source (output valid, average_out, ready_flag, samples_seen, input ready);
  modport sink   (input valid, average_out, ready_flag, samples_seen, output ready);

endinterface

[src/maf_div.sv]
// ----------------------------------------------------------------------------
// Moving average filter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module maf_div
  import maf_pkg::*;
#(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output maf_div_stat_t         stat_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIVIDEND_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[src/moving_average_filter.sv]
// ----------------------------------------------------------------------------
// Moving average filter
// Boxcar average over a programmable window with a circular sample store.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one word per operation: func selects a new sample, a
//   reset to the current average, or an init to the start_value register.
//   out_chan returns exactly one word per input word: the average, the
//   ready flag and the sample count after that operation.
//   The APB port sets window_length (0x0) and start_value (0x4); write it
//   only while the filter is idle.
// Sequence:
//   One word is in flight at a time. A sample word runs through EXEC,
//   START, WAIT and FINISH; in WAIT the divider produces one quotient
//   bit per cycle. Reset, init and unused codes go from EXEC straight
//   to FINISH. The next word is accepted once the filter is back in IDLE
//   after the previous result is loaded into the output register.
// Reset:
//   The store reads as zero, the window is 8, start_value is 0. No clearing
//   pass: a fill count marks which entries hold samples since the last
//   refill, the rest read as the fill value.
// Back pressure:
//   The result sits in an output register; the next word is accepted while
//   it waits, and its result is held until the register frees up.
// ----------------------------------------------------------------------------
`include "moving_average_filter_assert.svh"

module moving_average_filter
  import maf_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  maf_in_if.sink            in_chan,
  maf_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int S  = SAMPLE_BITS;
  localparam int WB = $clog2(WINDOW_MAX + 1);  // window register / fill count
  localparam int PB = $clog2(WINDOW_MAX);      // store address
  localparam int TB = S + PB;                  // running total

  // configuration
  logic [WB-1:0]       window_q;
  logic signed [S-1:0] start_q;
  logic                cfg_we;

  // control and filter state
  maf_state_e          state_q, state_d;
  logic [PB-1:0]       wpos_q, wpos_d;
  logic [WB-1:0]       hwm_q, hwm_d;
  logic signed [S-1:0] fill_q, fill_d;
  logic [TB-1:0]       total_q, total_d;
  logic signed [S-1:0] avg_q, avg_d;
  logic                ready_q, ready_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                out_valid_q, out_valid_d;

  // per-word payload
  logic [FUNC_W-1:0]   func_q;
  logic signed [S-1:0] sample_q;
  logic [PB-1:0]       pos_q;

  // output payload
  logic signed [S-1:0] out_avg_q;
  logic                out_flag_q;
  logic [COUNT_W-1:0]  out_count_q;

  // sample store
  logic [S-1:0]        sample_store [WINDOW_MAX];
  logic [S-1:0]        rd_q;
  logic [PB-1:0]       rd_addr;
  logic                st_we;

  // datapath
  logic [WB-1:0]       win;
  logic [PB-1:0]       pos_cur;
  logic                accept;
  logic                slot_free;
  logic                load_out;
  logic signed [S-1:0] old_val;
  logic [WB-1:0]       next_pos;
  logic signed [S-1:0] fill_src;
  logic signed [S+WB:0] prod;
  logic                div_start;
  logic [TB-1:0]       div_mag;
  logic [TB-1:0]       quot;
  maf_div_stat_t       div_stat;
  logic signed [TB:0]  q_signed;
  logic                q_fits;
  logic signed [S-1:0] q_sat;

  // --------------------------------------------------------------------------
  // Configuration port: zero-wait writes, address bit 2 picks the register
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_WINDOW: prdata[WB-1:0] = window_q;
      REG_START:  prdata[S-1:0]  = start_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WB'(WINDOW_RESET);
      start_q  <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_WINDOW) begin
        window_q <= pwdata[WB-1:0];
      end else begin
        start_q <= pwdata[S-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Effective window and write position
  // --------------------------------------------------------------------------
  always_comb begin
    if (window_q == '0) begin
      win = WB'(1);
    end else if (window_q > WB'(WINDOW_MAX)) begin
      win = WB'(WINDOW_MAX);
    end else begin
      win = window_q;
    end
  end

  // drop back to slot zero when the window shrank to or below the position
  assign pos_cur  = (WB'(wpos_q) < win) ? wpos_q : '0;
  assign next_pos = WB'(pos_q) + WB'(1);

  // entries at or above the fill count still hold the refill value
  assign old_val = (WB'(pos_q) < hwm_q) ? $signed(rd_q) : fill_q;

  // refill total: fill value times the window, wrapped to the total width
  assign fill_src = (func_q == FUNC_INIT) ? start_q : avg_q;
  assign prod     = fill_src * $signed({1'b0, win});

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_chan.ready = (state_q == ST_IDLE);
  assign accept        = in_chan.valid & in_chan.ready;
  assign slot_free     = !out_valid_q || out_chan.ready;

  // --------------------------------------------------------------------------
  // Divider on the magnitude of the total; sign is restored afterwards
  // --------------------------------------------------------------------------
  assign div_mag = total_q[TB-1] ? (TB'(0) - total_q) : total_q;

  maf_div #(
    .DIVIDEND_W (TB),
    .DIVISOR_W  (WB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (win),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  assign q_signed = total_q[TB-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  // saturate when the upper bits are not all sign copies
  assign q_fits   = (&q_signed[TB:S-1]) | ~(|q_signed[TB:S-1]);
  assign q_sat    = q_fits ? q_signed[S-1:0]
                  : (q_signed[TB] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}});

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    hwm_d       = hwm_q;
    fill_d      = fill_q;
    total_d     = total_q;
    avg_d       = avg_q;
    ready_d     = ready_q;
    count_d     = count_q;
    st_we       = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    rd_addr     = pos_cur;

    case (state_q)
      ST_IDLE: begin
        // read the slot about to be replaced while the word is latched
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (func_q)
          FUNC_SAMPLE: begin
            st_we   = 1'b1;
            total_d = total_q - {{(TB-S){old_val[S-1]}}, old_val}
                              + {{(TB-S){sample_q[S-1]}}, sample_q};
            wpos_d  = (next_pos >= win) ? '0 : next_pos[PB-1:0];
            hwm_d   = (next_pos > hwm_q) ? next_pos : hwm_q;
            count_d = count_q + COUNT_W'(1);
            ready_d = 1'b1;
            state_d = ST_START;
          end
          FUNC_RESET, FUNC_INIT: begin
            fill_d  = fill_src;
            avg_d   = fill_src;
            hwm_d   = '0;
            wpos_d  = '0;
            total_d = prod[TB-1:0];
            ready_d = 1'b0;
            count_d = '0;
            state_d = ST_FINISH;
          end
          default: begin
            // unused code: report the state unchanged
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          avg_d   = q_sat;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register frees up
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wpos_q      <= '0;
      hwm_q       <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      avg_q       <= '0;
      ready_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      hwm_q       <= hwm_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      avg_q       <= avg_d;
      ready_q     <= ready_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= in_chan.func;
      sample_q <= in_chan.sample_in;
      pos_q    <= pos_cur;
    end
    if (load_out) begin
      out_avg_q   <= avg_q;
      out_flag_q  <= ready_q;
      out_count_q <= count_q;
    end
  end

  // sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      sample_store[pos_q] <= sample_q;
    end
    rd_q <= sample_store[rd_addr];
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.average_out  = out_avg_q;
  assign out_chan.ready_flag   = out_flag_q;
  assign out_chan.samples_seen = out_count_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MAF_ASSERT_IMP(a_ready_div_idle, clk_i, rst_ni, in_chan.ready, !div_stat.busy, "input ready while divider runs")
  `MAF_ASSERT_IMP(a_done_in_wait, clk_i, rst_ni, div_stat.done, state_q == ST_WAIT, "divider done outside wait")
  `MAF_ASSERT_NXT(a_load_shows, clk_i, rst_ni, load_out, out_valid_q, "loaded result not presented")
  `MAF_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, hwm_q <= WB'(WINDOW_MAX), "fill count beyond store depth")

endmodule

[tb/sv/moving_average_filter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter testbench
// Streams sample, reset, init and unused-code words through the filter under
// bursty input and a stalling output. A shadow copy of the store and the
// running sum predicts each result word that the directed table does not
// give. A directed table comes first, then random phases that reprogram the
// window and the start value over APB while the filter is idle.
// ----------------------------------------------------------------------------
module moving_average_filter_tb;
  import maf_pkg::*;

  localparam int WINDOW_MAX         = 256;
  localparam int SAMPLE_BITS        = 16;
  localparam int TOTAL_W            = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int CLK_HALF           = 4;
  localparam int RESET_CYCLES       = 10;
  localparam int LONG_HOLD_CYCLES   = 500;
  localparam int HOLD_AFTER_RESULTS = 300;
  localparam int STALL_LIMIT        = 4000;
  localparam int TAIL_CYCLES        = 64;
  localparam int MAX_PRINTED        = 20;
  localparam int DIRECTED_ROWS      = 24;
  localparam int PHASES             = 9;

  // code 3 has no name in the package: the filter must ignore it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // byte addresses: register index sits on address bit 2
  localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_START  = {REG_START, 2'b00};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t            average;
    logic               flag;
    logic [COUNT_W-1:0] count;
  } avg_result_t;

  // one directed word; typed rows carry a result read straight off the spec
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    sample_t           sample;
    logic              typed;
    avg_result_t       result;
  } stim_row_t;

  typedef enum logic [1:0] {
    MIX_ANY,
    MIX_HIGH,
    MIX_LOW
  } sample_mix_e;

  // one random phase: filter setting, length and flavor of the traffic
  typedef struct packed {
    logic [8:0]  window;
    sample_t     start;
    logic [11:0] words;
    sample_mix_e mix;
    logic        refill_first;
    logic [5:0]  refill_pm;
  } phase_t;

  // Directed table, run from the reset setting (window 8, start value 0).
  localparam stim_row_t DIRECTED_TAB [DIRECTED_ROWS] = '{
    // unused code right after reset reports the cleared state
    '{FUNC_UNUSED, 16'sd0,     1'b1, '{16'sd0,     1'b0, 32'd0}},
    // fill the window with the largest sample
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b1, '{16'sd4095,  1'b1, 32'd1}},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh7FFF,  1'b1, '{16'sh7FFF,  1'b1, 32'd8}},
    // reset keeps the average, clears flag and count
    '{FUNC_RESET,  16'sh1234,  1'b1, '{16'sh7FFF,  1'b0, 32'd0}},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_UNUSED, 16'shFFFF,  1'b0, '0},
    // init loads the start value into store and average
    '{FUNC_INIT,   16'sh5555,  1'b1, '{16'sd0,     1'b0, 32'd0}},
    // fill the window with the smallest sample
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b0, '0},
    '{FUNC_SAMPLE, 16'sh8000,  1'b1, '{16'sh8000,  1'b1, 32'd8}},
    // negative totals truncate toward zero
    '{FUNC_SAMPLE, 16'sd0,     1'b0, '0},
    '{FUNC_SAMPLE, 16'sd1,     1'b0, '0},
    '{FUNC_SAMPLE, -16'sd1,    1'b0, '0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  maf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch  ();
  maf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  moving_average_filter #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_ch),
    .out_chan(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Shadow state of the filter and its two registers.
  sample_t                    shadow_store [WINDOW_MAX];
  int unsigned                shadow_pos;
  logic signed [TOTAL_W-1:0]  shadow_total;
  sample_t                    shadow_avg;
  logic                       shadow_flag;
  logic [COUNT_W-1:0]         shadow_count;
  logic [8:0]                 shadow_window;
  sample_t                    shadow_start;

  avg_result_t pending_averages [$];
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned settings_run;
  int unsigned burst_left;
  bit          long_hold_done;

  // Clamp the window register into 1..WINDOW_MAX.
  function automatic int unsigned live_window();
    if (shadow_window == 0) begin
      return 1;
    end
    if (shadow_window > WINDOW_MAX) begin
      return WINDOW_MAX;
    end
    return shadow_window;
  endfunction

  // Refill the whole store with one value and restart the count.
  function automatic void refill_store(sample_t fill);
    longint product;
    product = longint'(fill) * longint'(live_window());
    for (int i = 0; i < WINDOW_MAX; i++) begin
      shadow_store[i] = fill;
    end
    shadow_total = TOTAL_W'(product);
    shadow_pos   = 0;
    shadow_flag  = 1'b0;
    shadow_count = '0;
  endfunction

  // Apply one word to the shadow state and return the result it must produce.
  function automatic avg_result_t advance_filter(logic [FUNC_W-1:0] func, sample_t sample);
    int unsigned win;
    int unsigned pos;
    longint      quotient;
    avg_result_t res;
    win = live_window();
    case (func)
      FUNC_SAMPLE: begin
        // a shrunken window may leave the position past its end: restart at 0
        pos = (shadow_pos < win) ? shadow_pos : 0;
        // drop the oldest sample, add the new one, wrap at the sum width
        shadow_total = TOTAL_W'(longint'(shadow_total) - longint'(shadow_store[pos])
                                + longint'(sample));
        shadow_store[pos] = sample;
        shadow_pos = (pos + 1 >= win) ? 0 : pos + 1;
        quotient = longint'(shadow_total) / longint'(win);
        // only a mid-stream window change can push the quotient out of range
        if (quotient > 32767) begin
          quotient = 32767;
        end
        if (quotient < -32768) begin
          quotient = -32768;
        end
        shadow_avg   = sample_t'(quotient);
        shadow_count = shadow_count + 1'b1;
        shadow_flag  = 1'b1;
      end
      FUNC_RESET: begin
        refill_store(shadow_avg);
      end
      FUNC_INIT: begin
        shadow_avg = shadow_start;
        refill_store(shadow_avg);
      end
      default: begin
        // unused code: state stays, current state is reported
      end
    endcase
    res.average = shadow_avg;
    res.flag    = shadow_flag;
    res.count   = shadow_count;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // Two-phase APB write; the register takes the data at the access edge.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WINDOW) begin
      shadow_window = data[8:0];
    end else begin
      shadow_start = data[SAMPLE_BITS-1:0];
    end
    // return to idle before the next write so back-to-back writes never share a step
    @(posedge clk_i);
  endtask

  // Open a gap between bursts when the current burst has run out.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= sample_t'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      // mostly short bursts, now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // Offer one word, hold it until accepted, then record what it must return.
  task automatic send_word(input logic [FUNC_W-1:0] func, input sample_t sample,
                           input logic typed, input avg_result_t typed_res);
    avg_result_t predicted;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.sample_in <= sample;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predicted = advance_filter(func, sample);
    pending_averages.insert(pending_averages.size(), typed ? typed_res : predicted);
    words_sent++;
  endtask

  // Lower valid and hold until every pending result has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases with new settings.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    phase_t            plan [PHASES];
    int unsigned       roll;
    logic [FUNC_W-1:0] pick_func;
    sample_t           pick_sample;

    rst_ni          = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_SAMPLE;
    in_ch.sample_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    mismatch_count  = 0;
    words_sent      = 0;
    settings_run    = 1;
    burst_left      = 0;

    // shadow starts from the reset state
    for (int i = 0; i < WINDOW_MAX; i++) begin
      shadow_store[i] = '0;
    end
    shadow_pos    = 0;
    shadow_total  = '0;
    shadow_avg    = '0;
    shadow_flag   = 1'b0;
    shadow_count  = '0;
    shadow_window = 9'(WINDOW_RESET);
    shadow_start  = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      pace_sender();
      send_word(DIRECTED_TAB[i].func, DIRECTED_TAB[i].sample,
                DIRECTED_TAB[i].typed, DIRECTED_TAB[i].result);
    end

    // Phase plan: the widest window loaded near full scale, then shrunk
    // without a refill so the position lands past the window, the sum wraps
    // and the quotient saturates; out-of-range window codes at both ends.
    plan = '{
      '{9'd256, 16'sh7FFF,  12'd320, MIX_HIGH, 1'b1, 6'd1},
      '{9'd1,   16'sh8000,  12'd200, MIX_ANY,  1'b0, 6'd10},
      '{9'd0,   16'sd0,     12'd120, MIX_ANY,  1'b0, 6'd20},
      '{9'd511, 16'sh8000,  12'd320, MIX_LOW,  1'b1, 6'd1},
      '{9'd257, 16'sd12345, 12'd150, MIX_ANY,  1'b0, 6'd5},
      '{9'd3,   16'sh8000,  12'd200, MIX_LOW,  1'b0, 6'd10},
      '{9'd2,   16'sh7FFF,  12'd150, MIX_ANY,  1'b1, 6'd30},
      '{9'd8,   16'sd0,     12'd250, MIX_ANY,  1'b0, 6'd20},
      '{9'd8,   16'sd0,     12'd240, MIX_ANY,  1'b0, 6'd20}
    };
    plan[7].window = 9'($urandom_range(1, WINDOW_MAX));
    plan[7].start  = sample_t'($urandom);

    for (int p = 0; p < PHASES; p++) begin
      // reprogram only once the filter has nothing in flight
      wait_for_drain();
      apb_write(ADDR_WINDOW, APB_DW'(plan[p].window));
      apb_write(ADDR_START, {{(APB_DW - SAMPLE_BITS){1'b0}}, plan[p].start});
      settings_run++;
      if (plan[p].refill_first) begin
        send_word(FUNC_INIT, '0, 1'b0, '0);
      end
      for (int n = 0; n < int'(plan[p].words); n++) begin
        pace_sender();
        // mostly samples, a few refills per thousand, rare unused codes
        roll = $urandom_range(0, 999);
        if (roll < plan[p].refill_pm) begin
          pick_func = FUNC_RESET;
        end else if (roll < 2 * plan[p].refill_pm) begin
          pick_func = FUNC_INIT;
        end else if (roll < 2 * plan[p].refill_pm + 15) begin
          pick_func = FUNC_UNUSED;
        end else begin
          pick_func = FUNC_SAMPLE;
        end
        case (plan[p].mix)
          MIX_HIGH: begin
            pick_sample = ($urandom_range(0, 3) != 0) ? 16'sh7FFF : sample_t'($urandom);
          end
          MIX_LOW: begin
            pick_sample = ($urandom_range(0, 3) != 0) ? 16'sh8000 : sample_t'($urandom);
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       pick_sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
              1:       pick_sample = sample_t'(int'($urandom_range(0, 128)) - 64);
              default: pick_sample = sample_t'($urandom);
            endcase
          end
        endcase
        send_word(pick_func, pick_sample, 1'b0, '0);
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d words and %0d results over %0d filter settings",
             words_sent, results_seen, settings_run);
    $display("long output hold-off applied: %0d", long_hold_done);
    if (mismatch_count == 0) begin
      $display("moving_average_filter_tb: PASS");
    end else begin
      $display("moving_average_filter_tb: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stall on a pattern of its own, and once hold off long enough
  // for the filter to fill up and push back on its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned span;
    int unsigned mode;
    out_ch.ready <= 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    avg_result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_averages.size() == 0) begin
        flag_mismatch("result word with nothing pending", out_ch.average_out, 0);
      end else begin
        want = pending_averages.pop_front();
        if (out_ch.average_out !== want.average) begin
          flag_mismatch("average_out", out_ch.average_out, want.average);
        end
        if (out_ch.ready_flag !== want.flag) begin
          flag_mismatch("ready_flag", out_ch.ready_flag, want.flag);
        end
        if (out_ch.samples_seen !== want.count) begin
          flag_mismatch("samples_seen", out_ch.samples_seen, want.count);
        end
      end
    end
  end

  // End the run when no word moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    results_seen = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[%0t] timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("moving_average_filter_tb: FAIL");
    $finish;
  end

endmodule
